/* hdl/rwcp_pkg.sv */
// ----------------------------------------------------------------------------
// rwcp_pkg
// shared types and constants of the register write command packer
// ----------------------------------------------------------------------------
package rwcp_pkg;

   // request opcodes
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   localparam int WORD_ADDR_W = 30;
   localparam int DATA_W      = 32;
   localparam int OFFSET_W    = 6;
   localparam int EXTRA_W     = 2;
   localparam int SLOT_OUT_W  = 7;
   localparam int NODE_W      = 16;

   // a write joins when its word offset above the base is below this
   localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = 6'h3F;

   // most writes packed beyond the first one
   localparam logic [EXTRA_W-1:0] MAX_EXTRA = 2'd2;

endpackage

/* hdl/register_write_command_packer.sv */
// ----------------------------------------------------------------------------
// register_write_command_packer
// packs register writes into command items of up to three writes
// ----------------------------------------------------------------------------
// A stream of register writes (byte address, value) is packed into command
// items: a base word address with its data plus up to two more writes given
// as word offsets 1..62 above the base. A write that cannot join the open
// item emits that item and opens a new one in the next slot of the node.
// The item in the last slot of a node (ITEMS_PER_NODE-1) holds a single
// write; the following write emits it as end of node and opens slot 0 of the
// next node (node number wraps at 65536). A flush emits the open item, if
// any, marked end of node and end of list, and returns the block to its
// reset state. The packing decision (one 30-bit subtract and compare
// against the open base) is made as each request word is accepted, and any
// emitted item lands in the response register, so one request word is taken
// per clock while no emit waits on a held response. A request that emits
// nothing is taken even while a response word is held by rsp_stall; one that
// would emit waits until the response register frees up.
// ----------------------------------------------------------------------------
module register_write_command_packer #(
   parameter int ITEMS_PER_NODE = 128
) (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_reg_addr,
   input  logic [31:0] req_reg_value,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [29:0] rsp_base_word_addr,
   output logic [31:0] rsp_first_data,
   output logic [5:0]  rsp_second_offset,
   output logic [31:0] rsp_second_data,
   output logic [5:0]  rsp_third_offset,
   output logic [31:0] rsp_third_data,
   output logic [1:0]  rsp_extra_writes,
   output logic [6:0]  rsp_item_slot,
   output logic [15:0] rsp_node_number,
   output logic        rsp_node_end,
   output logic        rsp_list_end
);

   localparam int SLOT_W = $clog2(ITEMS_PER_NODE);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ITEMS_PER_NODE - 1);

   // open item state
   logic                                open_valid_ff, open_valid_in;
   logic [rwcp_pkg::WORD_ADDR_W-1:0]    open_base_ff, open_base_in;
   logic [rwcp_pkg::DATA_W-1:0]         open_data0_ff, open_data0_in;
   logic [rwcp_pkg::DATA_W-1:0]         open_data1_ff, open_data1_in;
   logic [rwcp_pkg::DATA_W-1:0]         open_data2_ff, open_data2_in;
   logic [rwcp_pkg::OFFSET_W-1:0]       open_off0_ff, open_off0_in;
   logic [rwcp_pkg::OFFSET_W-1:0]       open_off1_ff, open_off1_in;
   logic [rwcp_pkg::EXTRA_W-1:0]        open_extra_ff, open_extra_in;
   logic [SLOT_W-1:0]                   slot_ff, slot_in;
   logic [rwcp_pkg::NODE_W-1:0]         node_ff, node_in;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rwcp_pkg::WORD_ADDR_W-1:0]    rsp_base_ff, rsp_base_in;
   logic [rwcp_pkg::DATA_W-1:0]         rsp_data0_ff, rsp_data0_in;
   logic [rwcp_pkg::OFFSET_W-1:0]       rsp_off1_ff, rsp_off1_in;
   logic [rwcp_pkg::DATA_W-1:0]         rsp_data1_ff, rsp_data1_in;
   logic [rwcp_pkg::OFFSET_W-1:0]       rsp_off2_ff, rsp_off2_in;
   logic [rwcp_pkg::DATA_W-1:0]         rsp_data2_ff, rsp_data2_in;
   logic [rwcp_pkg::EXTRA_W-1:0]        rsp_extra_ff, rsp_extra_in;
   logic [rwcp_pkg::SLOT_OUT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [rwcp_pkg::NODE_W-1:0]         rsp_node_ff, rsp_node_in;
   logic                                rsp_node_end_ff, rsp_node_end_in;
   logic                                rsp_list_end_ff, rsp_list_end_in;

   // decode
   logic                                is_flush;
   logic [rwcp_pkg::WORD_ADDR_W-1:0]    word;
   logic [rwcp_pkg::WORD_ADDR_W-1:0]    diff;
   logic                                can_join;
   logic                                at_last_slot;
   logic                                emit;
   logic                                req_take;
   logic                                rsp_free;
   logic [SLOT_W+rwcp_pkg::SLOT_OUT_W-1:0] slot_wide;

   assign is_flush     = (req_opcode == rwcp_pkg::OP_FLUSH);
   assign word         = req_reg_addr[31:2];
   assign diff         = word - open_base_ff;
   // offset 1..62 above the base with room left in the item
   assign can_join     = (word > open_base_ff)
                       && (diff < rwcp_pkg::WORD_ADDR_W'(rwcp_pkg::OFFSET_LIMIT))
                       && (open_extra_ff < rwcp_pkg::MAX_EXTRA);
   assign at_last_slot = (slot_ff == LAST_SLOT);

   // an item leaves on a flush, at the last slot, or when the write won't fit
   assign emit = open_valid_ff && (is_flush || at_last_slot || !can_join);

   // response register frees up when empty or being taken this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = emit && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   // low bits of the slot index, zero extended for small nodes
   assign slot_wide = {{rwcp_pkg::SLOT_OUT_W{1'b0}}, slot_ff};

   // open item next state
   always_comb begin
      open_valid_in = open_valid_ff;
      open_base_in  = open_base_ff;
      open_data0_in = open_data0_ff;
      open_data1_in = open_data1_ff;
      open_data2_in = open_data2_ff;
      open_off0_in  = open_off0_ff;
      open_off1_in  = open_off1_ff;
      open_extra_in = open_extra_ff;
      slot_in       = slot_ff;
      node_in       = node_ff;
      if (req_take) begin
         priority if (is_flush) begin
            // back to the reset state
            open_valid_in = 1'b0;
            open_base_in  = '0;
            open_off0_in  = '0;
            open_off1_in  = '0;
            open_extra_in = '0;
            slot_in       = '0;
            node_in       = '0;
         end else if (open_valid_ff && !at_last_slot && can_join) begin
            // pack into the open item
            if (open_extra_ff == '0) begin
               open_off0_in  = diff[rwcp_pkg::OFFSET_W-1:0];
               open_data1_in = req_reg_value;
            end else begin
               open_off1_in  = diff[rwcp_pkg::OFFSET_W-1:0];
               open_data2_in = req_reg_value;
            end
            open_extra_in = open_extra_ff + 1'b1;
         end else begin
            // open a fresh item, moving slot and node on if one was closed
            if (open_valid_ff) begin
               if (at_last_slot) begin
                  slot_in = '0;
                  node_in = node_ff + 1'b1;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
            open_valid_in = 1'b1;
            open_base_in  = word;
            open_data0_in = req_reg_value;
            open_off0_in  = '0;
            open_off1_in  = '0;
            open_extra_in = '0;
         end
      end
   end

   // response register next state
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_base_in     = rsp_base_ff;
      rsp_data0_in    = rsp_data0_ff;
      rsp_off1_in     = rsp_off1_ff;
      rsp_data1_in    = rsp_data1_ff;
      rsp_off2_in     = rsp_off2_ff;
      rsp_data2_in    = rsp_data2_ff;
      rsp_extra_in    = rsp_extra_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_node_in     = rsp_node_ff;
      rsp_node_end_in = rsp_node_end_ff;
      rsp_list_end_in = rsp_list_end_ff;
      if (req_take && emit) begin
         rsp_valid_in    = 1'b1;
         rsp_base_in     = open_base_ff;
         rsp_data0_in    = open_data0_ff;
         // unused slots read as zero
         rsp_off1_in     = (open_extra_ff >= 2'd1) ? open_off0_ff : '0;
         rsp_data1_in    = (open_extra_ff >= 2'd1) ? open_data1_ff : '0;
         rsp_off2_in     = (open_extra_ff >= 2'd2) ? open_off1_ff : '0;
         rsp_data2_in    = (open_extra_ff >= 2'd2) ? open_data2_ff : '0;
         rsp_extra_in    = open_extra_ff;
         rsp_slot_in     = slot_wide[rwcp_pkg::SLOT_OUT_W-1:0];
         rsp_node_in     = node_ff;
         rsp_node_end_in = is_flush || at_last_slot;
         rsp_list_end_in = is_flush;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_valid_ff <= 1'b0;
         open_base_ff  <= '0;
         open_off0_ff  <= '0;
         open_off1_ff  <= '0;
         open_extra_ff <= '0;
         slot_ff       <= '0;
         node_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         open_valid_ff <= open_valid_in;
         open_base_ff  <= open_base_in;
         open_off0_ff  <= open_off0_in;
         open_off1_ff  <= open_off1_in;
         open_extra_ff <= open_extra_in;
         slot_ff       <= slot_in;
         node_ff       <= node_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      open_data0_ff   <= open_data0_in;
      open_data1_ff   <= open_data1_in;
      open_data2_ff   <= open_data2_in;
      rsp_base_ff     <= rsp_base_in;
      rsp_data0_ff    <= rsp_data0_in;
      rsp_off1_ff     <= rsp_off1_in;
      rsp_data1_ff    <= rsp_data1_in;
      rsp_off2_ff     <= rsp_off2_in;
      rsp_data2_ff    <= rsp_data2_in;
      rsp_extra_ff    <= rsp_extra_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_node_ff     <= rsp_node_in;
      rsp_node_end_ff <= rsp_node_end_in;
      rsp_list_end_ff <= rsp_list_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_base_word_addr = rsp_base_ff;
   assign rsp_first_data     = rsp_data0_ff;
   assign rsp_second_offset  = rsp_off1_ff;
   assign rsp_second_data    = rsp_data1_ff;
   assign rsp_third_offset   = rsp_off2_ff;
   assign rsp_third_data     = rsp_data2_ff;
   assign rsp_extra_writes   = rsp_extra_ff;
   assign rsp_item_slot      = rsp_slot_ff;
   assign rsp_node_number    = rsp_node_ff;
   assign rsp_node_end       = rsp_node_end_ff;
   assign rsp_list_end       = rsp_list_end_ff;

endmodule
